// ----- rtl/module_health_fault_monitor_unit_macros.svh -----
// Assertion macros for the health and fault monitor; they are empty when SYNTHESIS is defined.
`ifndef MODULE_HEALTH_FAULT_MONITOR_UNIT_MACROS_SVH
`define MODULE_HEALTH_FAULT_MONITOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold in the same cycle as the condition.
`define MHFM_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("health monitor assertion failed");
// The property must hold in the cycle after the condition.
`define MHFM_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("health monitor assertion failed");
`else
`define MHFM_ASSERT_IMP(name, cond, prop)
`define MHFM_ASSERT_NXT(name, cond, prop)
`endif
`endif

// ----- rtl/mhfm_pkg.sv -----
// Shared types, widths and codes of the health and fault monitor.
package mhfm_pkg;

    // Field widths
    localparam int BYTES_W    = 64;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int CODE_W     = 4;
    localparam int PCT_W      = 8;
    localparam int THR_W      = 7;
    localparam int SEL_W      = 2;
    localparam int SEV_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int LEVEL_W    = 2;
    localparam int FAULT_W    = 3;

    // Module table
    localparam int MODULE_COUNT_DEF = 3;
    localparam int STORAGE_INDEX    = 2;

    // Usage percent division: dividend is used bytes scaled by one hundred
    localparam int PCT_SCALE   = 100;
    localparam int SCALE_W     = 7;
    localparam int DIVIDEND_W  = BYTES_W + SCALE_W;
    localparam int DIV_STEPS   = DIVIDEND_W;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
    localparam int SUB_CNT_W   = $clog2(BYTES_W + 1);

    // Module status
    typedef enum logic [1:0] {
        ST_OK,
        ST_WARNING,
        ST_FAILED
    } status_t;

    // Report severities (the fourth code changes nothing)
    localparam logic [SEV_W-1:0] SEV_OK      = 2'd0;
    localparam logic [SEV_W-1:0] SEV_WARNING = 2'd1;
    localparam logic [SEV_W-1:0] SEV_FAILURE = 2'd2;

    // Commands
    localparam logic CMD_REPORT  = 1'b0;
    localparam logic CMD_STORAGE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WARN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL     = 2'd2;

    // Error codes raised by the storage grading
    localparam logic [CODE_W-1:0] CODE_NONE             = 4'd0;
    localparam logic [CODE_W-1:0] CODE_CARD_FULL        = 4'd3;
    localparam logic [CODE_W-1:0] CODE_STORAGE_WARNING  = 4'd8;
    localparam logic [CODE_W-1:0] CODE_STORAGE_CRITICAL = 4'd9;

    // Threshold reset values
    localparam logic [THR_W-1:0] WARN_RESET     = 7'd80;
    localparam logic [THR_W-1:0] CRITICAL_RESET = 7'd90;
    localparam logic [THR_W-1:0] FULL_RESET     = 7'd98;

    // Storage usage bands
    localparam logic [LEVEL_W-1:0] LVL_NORMAL   = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_WARNING  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_FULL     = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_DIVIDE,
        CS_APPLY,
        CS_DONE
    } ctrl_state_t;

    // Control of the serial arithmetic units
    typedef struct packed {
        logic load;
        logic step;
    } serial_ctrl_t;

    // Latched transaction fields used when the tables are updated
    typedef struct packed {
        logic              cmd;
        logic [SEL_W-1:0]  sel;
        logic [SEV_W-1:0]  sev;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] now;
        logic              total_zero;
    } item_t;

    // Usage thresholds
    typedef struct packed {
        logic [THR_W-1:0] warn;
        logic [THR_W-1:0] critical;
        logic [THR_W-1:0] full;
    } thresh_t;

endpackage

// ----- rtl/module_health_fault_monitor_unit.sv -----
// Health and fault monitor top level: command port, threshold registers and sequencer.
// A report goes from the accepting edge through the APPLY and DONE states; a storage update
// first runs, in DIVIDE, the 71-step bit-serial division that forms the usage percent.
// A new transaction is taken once busy falls; none is taken while one is in progress.
// Reset (rst_n low, asynchronous) clears all tables and loads thresholds of 80, 90 and 98.
// Each result is shown for one cycle under the done strobe; the receiver cannot stall.
`include "module_health_fault_monitor_unit_macros.svh"
module module_health_fault_monitor_unit #(
    parameter int MODULE_COUNT = mhfm_pkg::MODULE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    output logic                             done,
    input  logic                             cfg_we,
    input  logic [mhfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mhfm_pkg::THR_W-1:0]       cfg_data,
    input  logic                             command,
    input  logic [mhfm_pkg::SEL_W-1:0]       module_sel,
    input  logic [mhfm_pkg::SEV_W-1:0]       severity,
    input  logic [mhfm_pkg::CODE_W-1:0]      error_code,
    input  logic [mhfm_pkg::TIME_W-1:0]      now_ms,
    input  logic [mhfm_pkg::BYTES_W-1:0]     total_bytes,
    input  logic [mhfm_pkg::BYTES_W-1:0]     used_bytes,
    output logic [1:0]                       module_status,
    output logic [mhfm_pkg::CODE_W-1:0]      last_error,
    output logic [mhfm_pkg::COUNT_W-1:0]     error_count,
    output logic [mhfm_pkg::TIME_W-1:0]      last_ok_ms,
    output logic [mhfm_pkg::FAULT_W-1:0]     fault_bits,
    output logic                             any_warning,
    output logic                             any_failure,
    output logic                             all_healthy,
    output logic [mhfm_pkg::PCT_W-1:0]       usage_percent,
    output logic [mhfm_pkg::BYTES_W-1:0]     free_bytes,
    output logic [mhfm_pkg::LEVEL_W-1:0]     storage_level
);
    import mhfm_pkg::*;

    ctrl_state_t            state_reg;
    ctrl_state_t            state_next;
    logic [STEP_CNT_W-1:0]  step_cnt_reg;
    logic [STEP_CNT_W-1:0]  step_cnt_next;
    thresh_t                thr_reg;
    item_t                  item_reg;
    serial_ctrl_t           serial_ctrl;
    logic                   accept;
    logic                   apply;
    logic [PCT_W-1:0]       div_pct;
    logic [BYTES_W-1:0]     sub_free;

    assign busy   = (state_reg != CS_IDLE);
    assign done   = (state_reg == CS_DONE);
    assign accept = start && !busy;
    assign apply  = (state_reg == CS_APPLY);

    assign serial_ctrl.load = accept;
    assign serial_ctrl.step = (state_reg == CS_DIVIDE);

    // Threshold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.warn     <= WARN_RESET;
            thr_reg.critical <= CRITICAL_RESET;
            thr_reg.full     <= FULL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WARN:     thr_reg.warn     <= cfg_data;
                REG_CRITICAL: thr_reg.critical <= cfg_data;
                REG_FULL:     thr_reg.full     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Transaction fields are held until the result has been shown.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd        <= command;
            item_reg.sel        <= module_sel;
            item_reg.sev        <= severity;
            item_reg.code       <= error_code;
            item_reg.now        <= now_ms;
            item_reg.total_zero <= (total_bytes == '0);
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CS_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // Sequencer next state: updates run the division, reports go straight to the tables.
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    step_cnt_next = STEP_CNT_W'(DIV_STEPS - 1);
                    state_next    = (command == CMD_STORAGE) ? CS_DIVIDE : CS_APPLY;
                end
            end
            CS_DIVIDE:
            begin
                if (step_cnt_reg == '0)
                begin
                    state_next = CS_APPLY;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg - 1'b1;
                end
            end
            CS_APPLY:
            begin
                state_next = CS_DONE;
            end
            CS_DONE:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Serial arithmetic for the storage update.
    mhfm_serial_div u_div (
        .clk   (clk),
        .ctrl  (serial_ctrl),
        .total (total_bytes),
        .used  (used_bytes),
        .pct   (div_pct)
    );

    mhfm_serial_sub u_sub (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (serial_ctrl),
        .total (total_bytes),
        .used  (used_bytes),
        .free  (sub_free)
    );

    // Health tables and result fields.
    mhfm_health #(
        .MODULE_COUNT (MODULE_COUNT)
    ) u_health (
        .clk           (clk),
        .rst_n         (rst_n),
        .apply         (apply),
        .item          (item_reg),
        .pct           (div_pct),
        .free          (sub_free),
        .thr           (thr_reg),
        .module_status (module_status),
        .last_error    (last_error),
        .error_count   (error_count),
        .last_ok_ms    (last_ok_ms),
        .fault_bits    (fault_bits),
        .any_warning   (any_warning),
        .any_failure   (any_failure),
        .all_healthy   (all_healthy),
        .usage_percent (usage_percent),
        .free_bytes    (free_bytes),
        .storage_level (storage_level)
    );

    // Checks on the sequencer and on the health summary.
    `MHFM_ASSERT_NXT(a_accept_busy, accept, busy)
    `MHFM_ASSERT_NXT(a_done_single, done, !done)
    `MHFM_ASSERT_NXT(a_divide_exit, (state_reg == CS_DIVIDE) && (step_cnt_reg == '0), apply)
    `MHFM_ASSERT_IMP(a_healthy_status, all_healthy, !any_failure && !any_warning)

endmodule

// ----- rtl/mhfm_serial_sub.sv -----
// Bit-serial subtractor that forms the free bytes, floored at zero.
module mhfm_serial_sub (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mhfm_pkg::serial_ctrl_t         ctrl,
    input  logic [mhfm_pkg::BYTES_W-1:0]   total,
    input  logic [mhfm_pkg::BYTES_W-1:0]   used,
    output logic [mhfm_pkg::BYTES_W-1:0]   free
);
    import mhfm_pkg::*;

    logic [BYTES_W-1:0]   total_sr_reg;
    logic [BYTES_W-1:0]   used_sr_reg;
    logic [BYTES_W-1:0]   diff_sr_reg;
    logic                 borrow_reg;
    logic                 borrow_next;
    logic                 diff_bit;
    logic [SUB_CNT_W-1:0] cnt_reg;

    // One full-subtractor cell, least significant bit first.
    assign diff_bit    = total_sr_reg[0] ^ used_sr_reg[0] ^ borrow_reg;
    assign borrow_next = (~total_sr_reg[0] & used_sr_reg[0])
                       | (~(total_sr_reg[0] ^ used_sr_reg[0]) & borrow_reg);

    // Bit counter: the operands are shifted exactly once per bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= SUB_CNT_W'(BYTES_W);
        end
        else if (ctrl.step && (cnt_reg != '0))
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Operand and difference shift registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            total_sr_reg <= total;
            used_sr_reg  <= used;
            borrow_reg   <= 1'b0;
        end
        else if (ctrl.step && (cnt_reg != '0))
        begin
            total_sr_reg <= total_sr_reg >> 1;
            used_sr_reg  <= used_sr_reg >> 1;
            diff_sr_reg  <= {diff_bit, diff_sr_reg[BYTES_W-1:1]};
            borrow_reg   <= borrow_next;
        end
    end

    // A final borrow means the used bytes exceed the total.
    assign free = borrow_reg ? '0 : diff_sr_reg;

endmodule

// ----- rtl/mhfm_serial_div.sv -----
// Restoring divider, one quotient bit per cycle while ctrl.step is high, giving the saturated usage percent.
module mhfm_serial_div (
    input  logic                           clk,
    input  mhfm_pkg::serial_ctrl_t         ctrl,
    input  logic [mhfm_pkg::BYTES_W-1:0]   total,
    input  logic [mhfm_pkg::BYTES_W-1:0]   used,
    output logic [mhfm_pkg::PCT_W-1:0]     pct
);
    import mhfm_pkg::*;

    logic [DIVIDEND_W-1:0] dividend_reg;
    logic [BYTES_W-1:0]    divisor_reg;
    logic [BYTES_W-1:0]    rem_reg;
    logic [BYTES_W-1:0]    rem_next;
    logic [PCT_W-1:0]      quo_reg;
    logic                  sat_reg;
    logic [BYTES_W:0]      trial;
    logic [BYTES_W:0]      trial_diff;
    logic                  fits;

    // Bring down the next dividend bit and try to subtract the divisor.
    always_comb
    begin
        trial      = {rem_reg, dividend_reg[DIVIDEND_W-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        fits       = trial >= {1'b0, divisor_reg};
        rem_next   = fits ? trial_diff[BYTES_W-1:0] : trial[BYTES_W-1:0];
    end

    // Quotient bits shifted out of the top byte mark saturation.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dividend_reg <= DIVIDEND_W'(used) * DIVIDEND_W'(PCT_SCALE);
            divisor_reg  <= total;
            rem_reg      <= '0;
            quo_reg      <= '0;
            sat_reg      <= 1'b0;
        end
        else if (ctrl.step)
        begin
            dividend_reg <= {dividend_reg[DIVIDEND_W-2:0], 1'b0};
            rem_reg      <= rem_next;
            quo_reg      <= {quo_reg[PCT_W-2:0], fits};
            sat_reg      <= sat_reg | quo_reg[PCT_W-1];
        end
    end

    assign pct = sat_reg ? '1 : quo_reg;

endmodule

// ----- rtl/mhfm_health.sv -----
// Health tables of the monitored modules, their update rules and the result fields.
module mhfm_health #(
    parameter int MODULE_COUNT = mhfm_pkg::MODULE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           apply,
    input  mhfm_pkg::item_t                item,
    input  logic [mhfm_pkg::PCT_W-1:0]     pct,
    input  logic [mhfm_pkg::BYTES_W-1:0]   free,
    input  mhfm_pkg::thresh_t              thr,
    output logic [1:0]                     module_status,
    output logic [mhfm_pkg::CODE_W-1:0]    last_error,
    output logic [mhfm_pkg::COUNT_W-1:0]   error_count,
    output logic [mhfm_pkg::TIME_W-1:0]    last_ok_ms,
    output logic [mhfm_pkg::FAULT_W-1:0]   fault_bits,
    output logic                           any_warning,
    output logic                           any_failure,
    output logic                           all_healthy,
    output logic [mhfm_pkg::PCT_W-1:0]     usage_percent,
    output logic [mhfm_pkg::BYTES_W-1:0]   free_bytes,
    output logic [mhfm_pkg::LEVEL_W-1:0]   storage_level
);
    import mhfm_pkg::*;

    localparam int IDX_W = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
    localparam bit STORAGE_PRESENT = (STORAGE_INDEX < MODULE_COUNT);

    status_t            status_reg [MODULE_COUNT];
    logic [CODE_W-1:0]  error_reg  [MODULE_COUNT];
    logic [COUNT_W-1:0] count_reg  [MODULE_COUNT];
    logic [TIME_W-1:0]  stamp_reg  [MODULE_COUNT];
    logic [MODULE_COUNT-1:0] fault_reg;
    logic [PCT_W-1:0]   usage_reg;
    logic [BYTES_W-1:0] free_reg;

    logic              sel_in_range;
    logic              addr_valid;
    logic [IDX_W-1:0]  idx;
    status_t           cur_status;
    logic              do_ok;
    logic              do_bad;
    logic              do_clear;
    logic              do_usage;
    status_t           bad_status;
    logic [CODE_W-1:0] bad_code;
    logic [PCT_W-1:0]  warn_ext;
    logic [PCT_W-1:0]  crit_ext;
    logic [PCT_W-1:0]  full_ext;

    assign warn_ext = {1'b0, thr.warn};
    assign crit_ext = {1'b0, thr.critical};
    assign full_ext = {1'b0, thr.full};

    // Addressed module: the selected one for a report, the storage card for an update.
    assign sel_in_range = (int'(item.sel) < MODULE_COUNT);
    assign idx = (item.cmd == CMD_STORAGE) ? IDX_W'(STORAGE_INDEX) : IDX_W'(item.sel);
    assign addr_valid = (item.cmd == CMD_STORAGE) ? STORAGE_PRESENT : sel_in_range;
    assign cur_status = status_reg[idx];

    // Decode the transaction into one table action.
    always_comb
    begin
        do_ok      = 1'b0;
        do_bad     = 1'b0;
        do_clear   = 1'b0;
        do_usage   = 1'b0;
        bad_status = ST_WARNING;
        bad_code   = item.code;
        if (item.cmd == CMD_REPORT)
        begin
            if (sel_in_range)
            begin
                unique case (item.sev)
                    SEV_OK:
                    begin
                        do_ok = 1'b1;
                    end
                    SEV_WARNING:
                    begin
                        do_bad = 1'b1;
                    end
                    SEV_FAILURE:
                    begin
                        do_bad     = 1'b1;
                        bad_status = ST_FAILED;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else
        begin
            do_usage = 1'b1;
            if (!item.total_zero && STORAGE_PRESENT)
            begin
                if (pct >= full_ext)
                begin
                    do_bad     = 1'b1;
                    bad_status = ST_FAILED;
                    bad_code   = CODE_CARD_FULL;
                end
                else if (pct >= crit_ext)
                begin
                    do_bad   = 1'b1;
                    bad_code = CODE_STORAGE_CRITICAL;
                end
                else if (pct >= warn_ext)
                begin
                    do_bad   = 1'b1;
                    bad_code = CODE_STORAGE_WARNING;
                end
                else if (cur_status != ST_FAILED)
                begin
                    do_clear = 1'b1;
                end
            end
        end
    end

    // Table update, one entry per transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MODULE_COUNT; i++)
            begin
                status_reg[i] <= ST_OK;
                error_reg[i]  <= CODE_NONE;
                count_reg[i]  <= '0;
                stamp_reg[i]  <= '0;
            end
            fault_reg <= '0;
            usage_reg <= '0;
            free_reg  <= '0;
        end
        else if (apply)
        begin
            for (int i = 0; i < MODULE_COUNT; i++)
            begin
                if (idx == IDX_W'(i))
                begin
                    if (do_ok)
                    begin
                        status_reg[i] <= ST_OK;
                        error_reg[i]  <= CODE_NONE;
                        stamp_reg[i]  <= item.now;
                        fault_reg[i]  <= 1'b0;
                    end
                    else if (do_bad)
                    begin
                        status_reg[i] <= bad_status;
                        error_reg[i]  <= bad_code;
                        count_reg[i]  <= count_reg[i] + 1'b1;
                        fault_reg[i]  <= 1'b1;
                    end
                    else if (do_clear)
                    begin
                        status_reg[i] <= ST_OK;
                        error_reg[i]  <= CODE_NONE;
                        fault_reg[i]  <= 1'b0;
                    end
                end
            end
            if (do_usage)
            begin
                usage_reg <= item.total_zero ? '0 : pct;
                free_reg  <= free;
            end
        end
    end

    // Summary of all module states.
    always_comb
    begin
        any_warning = 1'b0;
        any_failure = 1'b0;
        for (int i = 0; i < MODULE_COUNT; i++)
        begin
            if (status_reg[i] == ST_WARNING)
            begin
                any_warning = 1'b1;
            end
            if (status_reg[i] == ST_FAILED)
            begin
                any_failure = 1'b1;
            end
        end
    end

    // Usage band of the stored percent.
    always_comb
    begin
        if (usage_reg >= full_ext)
        begin
            storage_level = LVL_FULL;
        end
        else if (usage_reg >= crit_ext)
        begin
            storage_level = LVL_CRITICAL;
        end
        else if (usage_reg >= warn_ext)
        begin
            storage_level = LVL_WARNING;
        end
        else
        begin
            storage_level = LVL_NORMAL;
        end
    end

    // Fields of the addressed module read as zero when it does not exist.
    assign module_status = addr_valid ? cur_status     : 2'b00;
    assign last_error    = addr_valid ? error_reg[idx] : '0;
    assign error_count   = addr_valid ? count_reg[idx] : '0;
    assign last_ok_ms    = addr_valid ? stamp_reg[idx] : '0;
    assign fault_bits    = FAULT_W'(fault_reg);
    assign all_healthy   = (fault_reg == '0);
    assign usage_percent = usage_reg;
    assign free_bytes    = free_reg;

endmodule
